// File: rtl/core/mtp_pkg.sv
// Shared types, constants and the tone table of the tune parser.
// No dependencies; imported by every module of the block.
package mtp_pkg;

	localparam int MAX_OCTAVE = 8;
	localparam logic [6:0] SHARP_LIMIT = 7'd84;
	localparam logic [7:0] TEMPO_MIN = 8'd32;
	localparam logic [17:0] DUR_UNIT = 18'd240000;
	localparam int NUM_W = 22;
	localparam int DEN_W = 25;

	typedef enum logic [10:0] {
		PH_HALT     = 11'b000_0000_0001,
		PH_CMD      = 11'b000_0000_0010,
		PH_NUM_L    = 11'b000_0000_0100,
		PH_NUM_O    = 11'b000_0000_1000,
		PH_NUM_T    = 11'b000_0001_0000,
		PH_NUM_P    = 11'b000_0010_0000,
		PH_NUM_R    = 11'b000_0100_0000,
		PH_MODE     = 11'b000_1000_0000,
		PH_NOTE_MOD = 11'b001_0000_0000,
		PH_NOTE_NUM = 11'b010_0000_0000,
		PH_DOTS     = 11'b100_0000_0000
	} phase_t;

	typedef enum logic [4:0] {
		C_IDLE   = 5'b00001,
		C_HANDLE = 5'b00010,
		C_DIVGO  = 5'b00100,
		C_DIV    = 5'b01000,
		C_OUT    = 5'b10000
	} ctl_t;

	typedef struct packed {
		logic        kind;
		logic [6:0]  note_index;
		logic [12:0] freq_hz;
		logic [15:0] duration_ms;
		logic        hold;
		logic        replay;
	} result_t;

	localparam logic [12:0] TONE_HZ [0:108] = '{13'd0,
		13'd16, 13'd17, 13'd18, 13'd19, 13'd21, 13'd22, 13'd23, 13'd25, 13'd26, 13'd28,
		13'd29, 13'd31,
		13'd33, 13'd35, 13'd37, 13'd39, 13'd41, 13'd44, 13'd46, 13'd49, 13'd52, 13'd55,
		13'd58, 13'd61,
		13'd65, 13'd69, 13'd73, 13'd78, 13'd82, 13'd87, 13'd92, 13'd98, 13'd104, 13'd110,
		13'd117, 13'd123,
		13'd131, 13'd139, 13'd147, 13'd156, 13'd165, 13'd175, 13'd185, 13'd196, 13'd208,
		13'd220, 13'd233, 13'd247,
		13'd262, 13'd277, 13'd294, 13'd311, 13'd330, 13'd349, 13'd370, 13'd392, 13'd415,
		13'd440, 13'd466, 13'd494,
		13'd523, 13'd554, 13'd587, 13'd622, 13'd659, 13'd698, 13'd740, 13'd784, 13'd831,
		13'd880, 13'd932, 13'd988,
		13'd1047, 13'd1109, 13'd1175, 13'd1245, 13'd1319, 13'd1397, 13'd1480, 13'd1568,
		13'd1661, 13'd1760, 13'd1865, 13'd1976,
		13'd2093, 13'd2217, 13'd2349, 13'd2489, 13'd2637, 13'd2794, 13'd2960, 13'd3136,
		13'd3322, 13'd3520, 13'd3729, 13'd3951,
		13'd4186, 13'd4435, 13'd4699, 13'd4978, 13'd5274, 13'd5588, 13'd5920, 13'd6272,
		13'd6645, 13'd7040, 13'd7459, 13'd7902};

	localparam logic [3:0] STEP_OF_LETTER [0:6] = '{4'd9, 4'd11, 4'd0, 4'd2, 4'd4,
		4'd5, 4'd7};

endpackage

// File: rtl/core/mml_tune_parser.sv
// Top level of the music-macro tune parser: command parsing and result buffer.
// Depends on mtp_pkg and the serial divider mtp_div.
//
// Usage: characters of a tune enter on ch with start_req on the in_valid/in_stall
// channel, one word per character. Results leave on out_valid/out_stall with
// kind, note_index, freq_hz, duration_ms, hold, replay and last; each character
// causes zero, one or two results, the final one flagged by last.
// Flow: a character that only changes state takes up to four parse passes.
// Each note or rest adds a bit-serial duration divide over 22 quotient bits
// before its result is stored and offered on the output channel.
// While results are pending or the parser is busy, in_stall stays high.
// A stalled result holds on the output ports until taken.
// After reset the parser is halted: characters are ignored until one arrives
// with start_req set. Octave is 4, tempo 120 and default length 4 after reset.
module mml_tune_parser
	import mtp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        start_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [6:0]  note_index,
	output logic [12:0] freq_hz,
	output logic [15:0] duration_ms,
	output logic        hold,
	output logic        replay,
	output logic        last
);

	ctl_t        ctl_q;
	phase_t      phase_q, phase_n;
	logic [15:0] acc_q, acc_n;
	logic [3:0]  oct_q, oct_n;
	logic [7:0]  tempo_q, tempo_n;
	logic [15:0] dlen_q, dlen_n;
	logic [15:0] slen_q, slen_n;
	logic [6:0]  note_q, note_n;
	logic [3:0]  dots_q, dots_n;
	logic        slur_q, slur_n;
	logic        rep_q, rep_n;
	logic        evp_q, evp_n;

	logic [7:0]  c_q;
	logic [1:0]  guard_q;
	logic        cont_q;
	logic [1:0]  cnt_q;
	logic        rd_q;
	result_t     slot_q [0:1];
	logic [6:0]  ev_note_q;
	logic        ev_slur_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;

	logic        again, emit_ev, emit_end, is_digit;
	logic [3:0]  dval;
	logic [19:0] acc10;
	logic [15:0] len_use;
	logic [7:0]  c_up;
	logic        in_acc, out_acc;
	logic        div_done;
	logic [15:0] div_quo;
	result_t     ev_res, end_res;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign c_up    = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;

	assign is_digit = c_q >= 8'h30 && c_q <= 8'h39;
	assign dval     = c_q[3:0];
	assign acc10    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, dval};
	assign len_use  = (slen_q != 16'd0) ? slen_q : dlen_q;

	// One pass of the parser over the held character.
	always_comb begin
		phase_n = phase_q; acc_n = acc_q; oct_n = oct_q; tempo_n = tempo_q;
		dlen_n = dlen_q; slen_n = slen_q; note_n = note_q; dots_n = dots_q;
		slur_n = slur_q; rep_n = rep_q; evp_n = evp_q;
		again = 1'b0; emit_ev = 1'b0; emit_end = 1'b0;
		case (phase_q)
			PH_CMD: begin
				acc_n = '0;
				if (c_q == 8'h4C) phase_n = PH_NUM_L;
				else if (c_q == 8'h4F) phase_n = PH_NUM_O;
				else if (c_q == 8'h54) phase_n = PH_NUM_T;
				else if (c_q == 8'h50 || c_q == 8'h52 || c_q == 8'h4E) begin
					note_n = '0;
					evp_n = 1'b1;
					phase_n = (c_q == 8'h50) ? PH_NUM_P : PH_NUM_R;
				end else if (c_q == 8'h3C) begin
					if (oct_q != 4'd0) oct_n = oct_q - 4'd1;
				end else if (c_q == 8'h3E) begin
					if (oct_q < 4'(MAX_OCTAVE)) oct_n = oct_q + 4'd1;
				end else if (c_q == 8'h4D) phase_n = PH_MODE;
				else if (c_q >= 8'h41 && c_q <= 8'h47) begin
					note_n = 7'({3'd0, STEP_OF_LETTER[3'(c_q - 8'h41)]} + 7'(oct_q) * 7'd12
						+ 7'd1);
					evp_n = 1'b1;
					phase_n = PH_NOTE_MOD;
				end else emit_end = 1'b1;
			end
			PH_NUM_L, PH_NUM_O, PH_NUM_T, PH_NUM_P, PH_NUM_R, PH_NOTE_NUM: begin
				if (is_digit) begin
					acc_n = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
				end else begin
					again = 1'b1;
					case (phase_q)
						PH_NUM_L: begin
							dlen_n = acc_q;
							if (acc_q == 16'd0) emit_end = 1'b1;
							else phase_n = PH_CMD;
						end
						PH_NUM_O: begin
							oct_n = (acc_q > 16'(MAX_OCTAVE)) ? 4'(MAX_OCTAVE) : acc_q[3:0];
							phase_n = PH_CMD;
						end
						PH_NUM_T: begin
							if (acc_q < 16'(TEMPO_MIN) || acc_q > 16'd255) emit_end = 1'b1;
							else begin
								tempo_n = acc_q[7:0];
								phase_n = PH_CMD;
							end
						end
						PH_NUM_P: begin
							dlen_n = acc_q;
							if (acc_q == 16'd0) emit_end = 1'b1;
							else phase_n = PH_DOTS;
						end
						PH_NUM_R: begin
							slen_n = acc_q;
							phase_n = PH_DOTS;
						end
						default: begin
							slen_n = acc_q;
							phase_n = PH_NOTE_MOD;
						end
					endcase
				end
			end
			PH_MODE: begin
				phase_n = PH_CMD;
				if (c_q == 8'h00) again = 1'b1;
				else if (c_q == 8'h42) rep_n = 1'b1;
				else if (c_q == 8'h46) rep_n = 1'b0;
			end
			PH_NOTE_MOD: begin
				if (c_q == 8'h23 || c_q == 8'h2B) begin
					if (note_q < SHARP_LIMIT) note_n = note_q + 7'd1;
				end else if (c_q == 8'h2D) begin
					if (note_q > 7'd1) note_n = note_q - 7'd1;
				end else if (is_digit) begin
					acc_n = {12'd0, dval};
					phase_n = PH_NOTE_NUM;
				end else if (c_q == 8'h2E) begin
					dots_n = 4'd1;
					phase_n = PH_DOTS;
				end else if (c_q == 8'h26) begin
					emit_ev = 1'b1;
				end else begin
					emit_ev = 1'b1;
					again = 1'b1;
				end
			end
			PH_DOTS: begin
				if (c_q == 8'h2E) begin
					if (dots_q != 4'd15) dots_n = dots_q + 4'd1;
				end else if (c_q == 8'h26 && note_q != 7'd0) begin
					emit_ev = 1'b1;
				end else begin
					emit_ev = 1'b1;
					again = 1'b1;
				end
			end
			default: ;
		endcase
		if (emit_ev || emit_end) begin
			acc_n = '0; slen_n = '0; note_n = '0; dots_n = '0; slur_n = 1'b0; evp_n = 1'b0;
			phase_n = emit_end ? PH_HALT : PH_CMD;
			if (emit_end) again = 1'b0;
		end
	end

	mtp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl_q == C_DIVGO),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		ev_res             = '0;
		ev_res.note_index  = ev_note_q;
		ev_res.freq_hz     = (ev_note_q <= 7'd108) ? TONE_HZ[ev_note_q] : 13'd0;
		ev_res.duration_ms = div_quo;
		ev_res.hold        = ev_slur_q;
		end_res            = '0;
		end_res.kind       = 1'b1;
		end_res.replay     = rep_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= C_IDLE; phase_q <= PH_HALT; acc_q <= '0; oct_q <= 4'd4;
			tempo_q <= 8'd120; dlen_q <= 16'd4; slen_q <= '0; note_q <= '0;
			dots_q <= '0; slur_q <= 1'b0; rep_q <= 1'b0; evp_q <= 1'b0;
			guard_q <= '0; cont_q <= 1'b0; cnt_q <= '0; rd_q <= 1'b0;
		end else begin
			case (ctl_q)
				C_IDLE: begin
					if (in_acc) begin
						cnt_q <= '0; rd_q <= 1'b0; guard_q <= '0;
						if (start_req) begin
							acc_q <= '0; slen_q <= '0; note_q <= '0; dots_q <= '0;
							slur_q <= 1'b0; evp_q <= 1'b0; phase_q <= PH_CMD;
						end
						if ((start_req || phase_q != PH_HALT) && ch != 8'h20 && ch != 8'h7C)
							ctl_q <= C_HANDLE;
					end
				end
				C_HANDLE: begin
					phase_q <= phase_n; acc_q <= acc_n; oct_q <= oct_n; tempo_q <= tempo_n;
					dlen_q <= dlen_n; slen_q <= slen_n; note_q <= note_n; dots_q <= dots_n;
					slur_q <= slur_n; rep_q <= rep_n; evp_q <= evp_n;
					guard_q <= guard_q + 2'd1;
					if (emit_end) begin
						cnt_q <= cnt_q + 2'd1;
						ctl_q <= C_OUT;
					end else if (emit_ev) begin
						cont_q <= again && guard_q != 2'd3;
						ctl_q <= C_DIVGO;
					end else if (!again || guard_q == 2'd3) begin
						ctl_q <= (cnt_q != 2'd0) ? C_OUT : C_IDLE;
					end
				end
				C_DIVGO: ctl_q <= C_DIV;
				C_DIV: begin
					if (div_done) begin
						cnt_q <= cnt_q + 2'd1;
						ctl_q <= cont_q ? C_HANDLE : C_OUT;
					end
				end
				C_OUT: begin
					if (out_acc) begin
						rd_q <= 1'b1;
						if ({1'b0, rd_q} == cnt_q - 2'd1) ctl_q <= C_IDLE;
					end
				end
				default: ctl_q <= C_IDLE;
			endcase
		end
	end

	// A rest followed by '&' is emitted unslurred; the '&' is then an error.
	always_ff @(posedge clk) begin
		if (ctl_q == C_IDLE && in_acc) c_q <= c_up;
		if (ctl_q == C_HANDLE && emit_ev) begin
			ev_note_q <= note_q;
			ev_slur_q <= (c_q == 8'h26) && (note_q != 7'd0);
			num_q <= NUM_W'(DUR_UNIT) * NUM_W'({1'b0, dots_q} + 5'd2);
			den_q <= DEN_W'({len_use, 1'b0}) * DEN_W'(tempo_q);
		end
		if (ctl_q == C_HANDLE && emit_end) slot_q[cnt_q[0]] <= end_res;
		if (ctl_q == C_DIV && div_done) slot_q[cnt_q[0]] <= ev_res;
	end

	assign in_stall    = ctl_q != C_IDLE;
	assign out_valid   = ctl_q == C_OUT;
	assign kind        = slot_q[rd_q].kind;
	assign note_index  = slot_q[rd_q].note_index;
	assign freq_hz     = slot_q[rd_q].freq_hz;
	assign duration_ms = slot_q[rd_q].duration_ms;
	assign hold        = slot_q[rd_q].hold;
	assign replay      = slot_q[rd_q].replay;
	assign last        = {1'b0, rd_q} == cnt_q - 2'd1;

	a_out_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cnt_q == 2'd1 || cnt_q == 2'd2)) else $error("output with no result");
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, rd_q} < cnt_q) else $error("read beyond stored results");
	a_end_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q == C_HANDLE && emit_end) |=> phase_q == PH_HALT) else $error("end without halt");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (ctl_q == C_IDLE || ctl_q == C_HANDLE)) else $error("bad state after accept");

endmodule

// File: rtl/core/mtp_div.sv
// Bit-serial restoring divider for the note duration, one quotient bit a cycle.
// Depends on mtp_pkg for the operand widths.
module mtp_div
	import mtp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [15:0]      quo
);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] sh_q;
	logic [DEN_W-1:0] den_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             take;

	assign trial = {rem_q, sh_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			sh_q  <= {sh_q[NUM_W-2:0], take};
		end
	end

	// A zero divisor yields all ones, which saturates the quotient.
	assign done = done_q;
	assign quo  = (|sh_q[NUM_W-1:16]) ? 16'hFFFF : sh_q[15:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q) else $error("divider busy and done together");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q < 5'(NUM_W)) else $error("divider count overrun");

endmodule
